>>> src/rkv_pkg.sv
// Shared types, register indexes and the half-step quadrature table.
`default_nettype none
package rkv_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] PRESS_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_STEPS_ATT  = 3'd0,
        REG_STEPS_CH   = 3'd1,
        REG_MAX_ATT    = 3'd2,
        REG_MAX_CH     = 3'd3,
        REG_PRESS_MIN  = 3'd4,
        REG_LONG_PRESS = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        QS_START         = 3'd0,
        QS_CCW_BEGIN     = 3'd1,
        QS_CW_BEGIN      = 3'd2,
        QS_START_MID     = 3'd3,
        QS_CW_BEGIN_MID  = 3'd4,
        QS_CCW_BEGIN_MID = 3'd5
    } quad_state_t;

    typedef struct packed {
        dir_t        emit;
        quad_state_t state;
    } quad_step_t;

    typedef struct packed {
        logic [3:0]  steps_per_attenuation;
        logic [3:0]  steps_per_channel;
        logic [7:0]  max_attenuation;
        logic [3:0]  max_channel;
        logic [15:0] press_min_ticks;
        logic [15:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic switch_level;
    } in_t;

    typedef struct packed {
        logic [7:0] attenuation;
        logic [3:0] channel;
        logic       control_mode;
        logic [1:0] step_event;
        logic       store_default;
    } res_t;

    // Half-step table: pins are {a, b}; unused state codes behave as start.
    function automatic quad_step_t quad_lookup(input quad_state_t st, input logic [1:0] pins);
        quad_step_t r;
        r.emit  = DIR_IDLE;
        r.state = QS_START;
        case (st)
            QS_CCW_BEGIN: begin
                case (pins)
                    2'd0: begin r.state = QS_START_MID; r.emit = DIR_CCW; end
                    2'd1: r.state = QS_START;
                    2'd2: r.state = QS_CCW_BEGIN;
                    default: r.state = QS_START;
                endcase
            end
            QS_CW_BEGIN: begin
                case (pins)
                    2'd0: begin r.state = QS_START_MID; r.emit = DIR_CW; end
                    2'd1: r.state = QS_CW_BEGIN;
                    2'd2: r.state = QS_START;
                    default: r.state = QS_START;
                endcase
            end
            QS_START_MID: begin
                case (pins)
                    2'd0: r.state = QS_START_MID;
                    2'd1: r.state = QS_CCW_BEGIN_MID;
                    2'd2: r.state = QS_CW_BEGIN_MID;
                    default: r.state = QS_START;
                endcase
            end
            QS_CW_BEGIN_MID: begin
                case (pins)
                    2'd0: r.state = QS_START_MID;
                    2'd1: r.state = QS_START_MID;
                    2'd2: r.state = QS_CW_BEGIN_MID;
                    default: begin r.state = QS_START; r.emit = DIR_CW; end
                endcase
            end
            QS_CCW_BEGIN_MID: begin
                case (pins)
                    2'd0: r.state = QS_START_MID;
                    2'd1: r.state = QS_CCW_BEGIN_MID;
                    2'd2: r.state = QS_START_MID;
                    default: begin r.state = QS_START; r.emit = DIR_CCW; end
                endcase
            end
            default: begin
                case (pins)
                    2'd0: r.state = QS_START_MID;
                    2'd1: r.state = QS_CW_BEGIN;
                    2'd2: r.state = QS_CCW_BEGIN;
                    default: r.state = QS_START;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/rkv_apb_regs.sv
// APB configuration registers for step thresholds, limits and press times.
`default_nettype none
module rkv_apb_regs import rkv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_STEPS_ATT:  cfg_next.steps_per_attenuation = pwdata[3:0];
                REG_STEPS_CH:   cfg_next.steps_per_channel     = pwdata[3:0];
                REG_MAX_ATT:    cfg_next.max_attenuation       = pwdata[7:0];
                REG_MAX_CH:     cfg_next.max_channel           = pwdata[3:0];
                REG_PRESS_MIN:  cfg_next.press_min_ticks       = pwdata[15:0];
                REG_LONG_PRESS: cfg_next.long_press_ticks      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steps_per_attenuation <= 4'd2;
            cfg_reg.steps_per_channel     <= 4'd4;
            cfg_reg.max_attenuation       <= 8'd255;
            cfg_reg.max_channel           <= 4'd3;
            cfg_reg.press_min_ticks       <= 16'd50;
            cfg_reg.long_press_ticks      <= 16'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_STEPS_ATT:  prdata = {28'd0, cfg_reg.steps_per_attenuation};
            REG_STEPS_CH:   prdata = {28'd0, cfg_reg.steps_per_channel};
            REG_MAX_ATT:    prdata = {24'd0, cfg_reg.max_attenuation};
            REG_MAX_CH:     prdata = {28'd0, cfg_reg.max_channel};
            REG_PRESS_MIN:  prdata = {16'd0, cfg_reg.press_min_ticks};
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> src/rkv_knob_core.sv
// Knob state: quadrature decode, step counting, level update and press timing.
`default_nettype none
module rkv_knob_core import rkv_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  in_t       item,
    input  cfg_t      cfg,
    output res_t      result
);

    quad_state_t quad_state_reg, quad_state_next;
    dir_t        last_dir_reg, last_dir_next;
    logic [4:0]  step_count_reg [2];
    logic [4:0]  step_count_next [2];
    logic [7:0]  att_reg, att_next;
    logic [3:0]  ch_reg, ch_next;
    logic        mode_reg, mode_next;
    logic [15:0] press_reg, press_next;

    quad_step_t         qs;
    dir_t               dir;
    logic [4:0]         cnt_cur;
    logic signed [5:0]  cnt_base, cnt_inc, thr;
    logic               hit_up, hit_dn;
    logic signed [9:0]  att_calc;
    logic signed [5:0]  ch_calc;
    logic               store;

    always_comb begin
        qs  = quad_lookup(quad_state_reg, {item.pin_a, item.pin_b});
        dir = qs.emit;

        quad_state_next    = qs.state;
        last_dir_next      = last_dir_reg;
        step_count_next[0] = step_count_reg[0];
        step_count_next[1] = step_count_reg[1];
        att_next           = att_reg;
        ch_next            = ch_reg;
        mode_next          = mode_reg;
        press_next         = press_reg;
        store              = 1'b0;

        // Count in the mode in force at the start of the tick; clear on reversal.
        cnt_cur  = step_count_reg[mode_reg];
        cnt_base = (last_dir_reg != dir) ? 6'sd0 : $signed({cnt_cur[4], cnt_cur});
        cnt_inc  = (dir == DIR_CW) ? cnt_base + 6'sd1 : cnt_base - 6'sd1;
        thr      = $signed({2'b00, mode_reg ? cfg.steps_per_channel
                                            : cfg.steps_per_attenuation});
        hit_up   = cnt_inc >= thr;
        hit_dn   = !hit_up && (cnt_inc <= -thr);

        att_calc = $signed({2'b00, att_reg});
        if (hit_up) begin
            att_calc = att_calc - 10'sd1;
        end else if (hit_dn) begin
            att_calc = att_calc + 10'sd1;
        end
        ch_calc = $signed({2'b00, ch_reg});
        if (hit_up) begin
            ch_calc = ch_calc + 6'sd1;
        end else if (hit_dn) begin
            ch_calc = ch_calc - 6'sd1;
        end

        if (dir != DIR_IDLE) begin
            last_dir_next             = dir;
            step_count_next[mode_reg] = (hit_up || hit_dn) ? 5'd0 : cnt_inc[4:0];
            if (!mode_reg) begin
                // Saturate between zero and the limit.
                if (att_calc > $signed({2'b00, cfg.max_attenuation})) begin
                    att_next = cfg.max_attenuation;
                end else if (att_calc < 10'sd0) begin
                    att_next = 8'd0;
                end else begin
                    att_next = att_calc[7:0];
                end
            end else begin
                // Wrap round between zero and the highest channel.
                if (ch_calc > $signed({2'b00, cfg.max_channel})) begin
                    ch_next = 4'd0;
                end else if (ch_calc < 6'sd0) begin
                    ch_next = cfg.max_channel;
                end else begin
                    ch_next = ch_calc[3:0];
                end
            end
        end

        if (!item.switch_level) begin
            if (press_reg != PRESS_SAT) begin
                press_next = press_reg + 16'd1;
            end
        end else begin
            if (press_reg >= cfg.press_min_ticks) begin
                if (press_reg >= cfg.long_press_ticks) begin
                    store = 1'b1;
                end else begin
                    mode_next                  = !mode_reg;
                    last_dir_next              = DIR_IDLE;
                    step_count_next[!mode_reg] = 5'd0;
                end
            end
            press_next = 16'd0;
        end

        result.attenuation   = att_next;
        result.channel       = ch_next;
        result.control_mode  = mode_next;
        result.step_event    = dir;
        result.store_default = store;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_state_reg    <= QS_START;
            last_dir_reg      <= DIR_IDLE;
            step_count_reg[0] <= 5'd0;
            step_count_reg[1] <= 5'd0;
            att_reg           <= 8'd0;
            ch_reg            <= 4'd0;
            mode_reg          <= 1'b0;
            press_reg         <= 16'd0;
        end else if (advance) begin
            quad_state_reg    <= quad_state_next;
            last_dir_reg      <= last_dir_next;
            step_count_reg[0] <= step_count_next[0];
            step_count_reg[1] <= step_count_next[1];
            att_reg           <= att_next;
            ch_reg            <= ch_next;
            mode_reg          <= mode_next;
            press_reg         <= press_next;
        end
    end

    // A store pulse never toggles the mode.
    a_store_keeps_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.store_default) |=> (mode_reg == $past(mode_reg)))
        else $error("mode changed on a long press");

    // Step counts never reach -16, which lies beyond every threshold.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_count_reg[0] != 5'b10000) && (step_count_reg[1] != 5'b10000))
        else $error("step count out of range");

endmodule
`default_nettype wire

>>> src/rotary_knob_volume_channel_control.sv
// Top level: input register, knob core, result register and APB registers.
//
// Rotary knob volume / channel control. Each request on the s_ channel is one
// timer tick: the levels of encoder pins A and B and of the active-low push
// switch. Each tick gives exactly one request on the m_ channel with the
// attenuation, channel and mode after that tick, the step seen in it and a
// one-tick store_default flag raised on release of a long press.
// Both channels use valid/ready. A request taken sits in the input register,
// is decoded against the knob state as it advances into the result register
// and appears on the m_ ports from then on. Throughput is one tick per cycle
// while the receiver does not stall; the state update is a single pass of
// table lookup, small add and compare between the two registers.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops only while both are full.
// The APB port (always ready) sets step thresholds, limits and press times;
// write it only while no request is in flight.
// Synchronous active-low reset clears the pipeline, the knob state to volume
// mode, channel 0 and attenuation 0, and loads the register defaults.
`default_nettype none
module rotary_knob_volume_channel_control import rkv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_pin_a,
    input  wire logic                  s_pin_b,
    input  wire logic                  s_switch_level,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_attenuation,
    output logic [3:0]                 m_channel,
    output logic                       m_control_mode,
    output logic [1:0]                 m_step_event,
    output logic                       m_store_default,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;
    logic in_valid_reg;
    in_t  in_item_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    res_t core_res;
    logic advance;

    rkv_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rkv_knob_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_res)
    );

    // Move a request forward when the result register is free or being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.pin_a        <= s_pin_a;
            in_item_reg.pin_b        <= s_pin_b;
            in_item_reg.switch_level <= s_switch_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_attenuation   = out_res_reg.attenuation;
    assign m_channel       = out_res_reg.channel;
    assign m_control_mode  = out_res_reg.control_mode;
    assign m_step_event    = out_res_reg.step_event;
    assign m_store_default = out_res_reg.store_default;

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced request lost before result register");

    a_accept_fills_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted request not held in input register");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

endmodule
`default_nettype wire

>>> dv/rotary_knob_volume_channel_control_test.sv
// Self-checking testbench for the rotary knob volume / channel control block.
`timescale 1ns / 100ps

module rotary_knob_volume_channel_control_test;
    import rkv_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RX_LONG_HOLD   = 80;
    localparam int RANDOM_PHASES  = 6;
    localparam int RANDOM_TICKS   = 65;
    localparam int DRAIN_CYCLES   = 8;
    // Clockwise pin order {a, b} by position: 11, 01, 00, 10
    localparam logic [7:0] GRAY_CW = {2'b10, 2'b00, 2'b01, 2'b11};

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_pin_a         = 1'b1;
    logic                  s_pin_b         = 1'b1;
    logic                  s_switch_level  = 1'b1;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [7:0]            m_attenuation;
    logic [3:0]            m_channel;
    logic                  m_control_mode;
    logic [1:0]            m_step_event;
    logic                  m_store_default;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rotary_knob_volume_channel_control dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pin_a         (s_pin_a),
        .s_pin_b         (s_pin_b),
        .s_switch_level  (s_switch_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_attenuation   (m_attenuation),
        .m_channel       (m_channel),
        .m_control_mode  (m_control_mode),
        .m_step_event    (m_step_event),
        .m_store_default (m_store_default),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Register copy used for prediction
    logic [3:0]  cfg_steps_att;
    logic [3:0]  cfg_steps_ch;
    logic [7:0]  cfg_max_att;
    logic [3:0]  cfg_max_ch;
    logic [15:0] cfg_press_min;
    logic [15:0] cfg_long_press;

    // Knob state copy
    quad_state_t knob_qs;
    dir_t        knob_last;
    int          knob_cnt [2];
    logic [7:0]  knob_att;
    logic [3:0]  knob_ch;
    logic        knob_mode;
    logic [15:0] knob_press;

    in_t         pending [$];
    res_t        tick_exp [$];
    in_t         cur;
    res_t        want;

    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    int unsigned s_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_draw;
    int unsigned tx_idle_max = 7;
    int unsigned rx_idle_max = 7;
    int unsigned rx_long_cnt = 0;
    int unsigned rx_long_seen = 0;
    int unsigned quiet_cycles = 0;

    int          gen_pos = 0;
    int          queued = 0;
    int          errors = 0;
    int          ticks_in = 0;
    int          results_seen = 0;
    int          store_seen = 0;
    int          mode_changes = 0;
    int          settings = 0;
    logic        seen_mode = 1'b0;

    function automatic quad_step_t qstep(dir_t d, quad_state_t s);
        quad_step_t r;
        r.emit  = d;
        r.state = s;
        return r;
    endfunction

    // Half-step decoder, pins {a, b}; stray codes fall back to the start row
    function automatic quad_step_t half_step(quad_state_t st, logic [1:0] pins);
        quad_step_t r;
        r = qstep(DIR_IDLE, QS_START);
        case (st)
            QS_CCW_BEGIN: begin
                case (pins)
                    2'b00: r = qstep(DIR_CCW, QS_START_MID);
                    2'b10: r = qstep(DIR_IDLE, QS_CCW_BEGIN);
                    default: r = qstep(DIR_IDLE, QS_START);
                endcase
            end
            QS_CW_BEGIN: begin
                case (pins)
                    2'b00: r = qstep(DIR_CW, QS_START_MID);
                    2'b01: r = qstep(DIR_IDLE, QS_CW_BEGIN);
                    default: r = qstep(DIR_IDLE, QS_START);
                endcase
            end
            QS_START_MID: begin
                case (pins)
                    2'b00: r = qstep(DIR_IDLE, QS_START_MID);
                    2'b01: r = qstep(DIR_IDLE, QS_CCW_BEGIN_MID);
                    2'b10: r = qstep(DIR_IDLE, QS_CW_BEGIN_MID);
                    default: r = qstep(DIR_IDLE, QS_START);
                endcase
            end
            QS_CW_BEGIN_MID: begin
                case (pins)
                    2'b00, 2'b01: r = qstep(DIR_IDLE, QS_START_MID);
                    2'b10: r = qstep(DIR_IDLE, QS_CW_BEGIN_MID);
                    default: r = qstep(DIR_CW, QS_START);
                endcase
            end
            QS_CCW_BEGIN_MID: begin
                case (pins)
                    2'b00, 2'b10: r = qstep(DIR_IDLE, QS_START_MID);
                    2'b01: r = qstep(DIR_IDLE, QS_CCW_BEGIN_MID);
                    default: r = qstep(DIR_CCW, QS_START);
                endcase
            end
            default: begin
                case (pins)
                    2'b00: r = qstep(DIR_IDLE, QS_START_MID);
                    2'b01: r = qstep(DIR_IDLE, QS_CW_BEGIN);
                    2'b10: r = qstep(DIR_IDLE, QS_CCW_BEGIN);
                    default: r = qstep(DIR_IDLE, QS_START);
                endcase
            end
        endcase
        return r;
    endfunction

    // One encoder step in the mode in force at the start of the tick
    function automatic void knob_step(dir_t d);
        int   v;
        int   thr;
        logic m;
        m = knob_mode;
        if (knob_last != d) knob_cnt[m] = 0;
        knob_last = d;
        knob_cnt[m] += (d == DIR_CW) ? 1 : -1;
        if (!m) begin
            thr = int'(cfg_steps_att);
            v   = int'(knob_att);
            if (knob_cnt[m] >= thr) begin
                v--;
                knob_cnt[m] = 0;
            end else if (knob_cnt[m] <= -thr) begin
                v++;
                knob_cnt[m] = 0;
            end
            // clamp even without a threshold crossing
            if (v > int'(cfg_max_att)) v = int'(cfg_max_att);
            else if (v < 0) v = 0;
            knob_att = v[7:0];
        end else begin
            thr = int'(cfg_steps_ch);
            v   = int'(knob_ch);
            if (knob_cnt[m] >= thr) begin
                v++;
                knob_cnt[m] = 0;
            end else if (knob_cnt[m] <= -thr) begin
                v--;
                knob_cnt[m] = 0;
            end
            if (v > int'(cfg_max_ch)) v = 0;
            else if (v < 0) v = int'(cfg_max_ch);
            knob_ch = v[3:0];
        end
    endfunction

    function automatic res_t knob_tick(logic a, logic b, logic sw);
        quad_step_t nx;
        res_t       r;
        nx      = half_step(knob_qs, {a, b});
        knob_qs = nx.state;
        if (nx.emit != DIR_IDLE) knob_step(nx.emit);
        r.store_default = 1'b0;
        if (!sw) begin
            if (knob_press != PRESS_SAT) knob_press++;
        end else begin
            if (knob_press >= cfg_press_min) begin
                if (knob_press >= cfg_long_press) begin
                    r.store_default = 1'b1;
                end else begin
                    knob_mode = ~knob_mode;
                    knob_last = DIR_IDLE;
                    knob_cnt[knob_mode] = 0;
                end
            end
            knob_press = '0;
        end
        r.attenuation  = knob_att;
        r.channel      = knob_ch;
        r.control_mode = knob_mode;
        r.step_event   = nx.emit;
        return r;
    endfunction

    task automatic cmp_field(string label, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, label, exp_val,
                     act_val);
        end
    endtask

    // Write one register over APB, then read it back
    task automatic set_reg(reg_index_t idx, logic [31:0] val);
        logic [31:0] mask;
        mask = 32'hFFFF;
        case (idx)
            REG_STEPS_ATT: begin
                mask = 32'hF;
                cfg_steps_att = val[3:0];
            end
            REG_STEPS_CH: begin
                mask = 32'hF;
                cfg_steps_ch = val[3:0];
            end
            REG_MAX_ATT: begin
                mask = 32'hFF;
                cfg_max_att = val[7:0];
            end
            REG_MAX_CH: begin
                mask = 32'hF;
                cfg_max_ch = val[3:0];
            end
            REG_PRESS_MIN: cfg_press_min = val[15:0];
            default: cfg_long_press = val[15:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cmp_field("register readback", val & mask, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_all(int unsigned sa, int unsigned sc, int unsigned ma, int unsigned mc,
                           int unsigned pm, int unsigned pl);
        set_reg(REG_STEPS_ATT, sa);
        set_reg(REG_STEPS_CH, sc);
        set_reg(REG_MAX_ATT, ma);
        set_reg(REG_MAX_CH, mc);
        set_reg(REG_PRESS_MIN, pm);
        set_reg(REG_LONG_PRESS, pl);
        settings++;
        @(posedge aclk);
    endtask

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(3, 0))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic random_setting();
        logic [15:0] pmin;
        logic [15:0] plong;
        pmin = ($urandom_range(7, 0) == 0) ? PRESS_SAT : 16'($urandom_range(6, 1));
        case ($urandom_range(3, 0))
            0: plong = 16'd1;
            1: plong = PRESS_SAT;
            default: plong = (pmin == PRESS_SAT) ? PRESS_SAT : pmin + 16'($urandom_range(10, 0));
        endcase
        set_all(pick(1, 15), pick(1, 15), pick(0, 255), pick(0, 15), 32'(pmin), 32'(plong));
    endtask

    task automatic queue_tick(logic sw);
        in_t t;
        t.pin_a        = GRAY_CW[gen_pos * 2 + 1];
        t.pin_b        = GRAY_CW[gen_pos * 2];
        t.switch_level = sw;
        pending.push_back(t);
        queued++;
    endtask

    // Two half-step transitions per detent step
    task automatic turn(dir_t d, int steps, logic sw);
        for (int i = 0; i < 2 * steps; i++) begin
            gen_pos = (d == DIR_CW) ? (gen_pos + 1) % 4 : (gen_pos + 3) % 4;
            queue_tick(sw);
        end
    endtask

    task automatic hold_switch(int n);
        repeat (n) queue_tick(1'b0);
        queue_tick(1'b1);
    endtask

    task automatic random_ticks(int n);
        int start;
        int kind;
        int cap;
        start = queued;
        cap = (cfg_long_press < 20) ? cfg_long_press + 2 :
              (cfg_press_min < 20) ? cfg_press_min + 2 : 20;
        while (queued - start < n) begin
            kind = $urandom_range(9, 0);
            if (kind <= 5) begin
                turn($urandom_range(1, 0) ? DIR_CW : DIR_CCW, $urandom_range(6, 1),
                     $urandom_range(7, 0) != 0);
            end else if (kind <= 7) begin
                hold_switch($urandom_range(cap, 0));
            end else if (kind == 8) begin
                // jump to arbitrary pin levels
                repeat ($urandom_range(4, 1)) begin
                    gen_pos = $urandom_range(3, 0);
                    queue_tick(1'($urandom_range(1, 0)));
                end
            end else begin
                // half a step forward and back again
                gen_pos = (gen_pos + 1) % 4;
                queue_tick(1'b1);
                gen_pos = (gen_pos + 3) % 4;
                queue_tick(1'b1);
            end
        end
    endtask

    task automatic wait_drain();
        while (pending.size() != 0 || s_valid || tick_exp.size() != 0) @(posedge aclk);
    endtask

    // Request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (s_wait != 0) begin
                s_valid <= 1'b0;
                s_wait  <= s_wait - 1;
            end else if (pending.size() != 0) begin
                cur = pending.pop_front();
                s_pin_a        <= cur.pin_a;
                s_pin_b        <= cur.pin_b;
                s_switch_level <= cur.switch_level;
                s_valid        <= 1'b1;
                s_wait         <= $urandom_range(tx_idle_max, 0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_long_seen != rx_long_cnt) begin
                rx_long_seen <= rx_long_cnt;
                rx_wait      <= RX_LONG_HOLD;
                m_ready      <= 1'b0;
            end else if (rx_wait != 0) begin
                m_ready <= 1'b0;
                rx_wait <= rx_wait - 1;
            end else if (m_took) begin
                rx_draw = $urandom_range(rx_idle_max, 0);
                if (rx_draw == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    rx_wait <= rx_draw - 1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        m_took <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            tick_exp.push_back(knob_tick(s_pin_a, s_pin_b, s_switch_level));
            ticks_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_store_default) store_seen++;
            if (m_control_mode != seen_mode) mode_changes++;
            seen_mode = m_control_mode;
            if (tick_exp.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual att %0d ch %0d mode %0d",
                         $time, m_attenuation, m_channel, m_control_mode);
            end else begin
                want = tick_exp.pop_front();
                cmp_field("attenuation", 32'(want.attenuation), 32'(m_attenuation));
                cmp_field("channel", 32'(want.channel), 32'(m_channel));
                cmp_field("control_mode", 32'(want.control_mode), 32'(m_control_mode));
                cmp_field("step_event", 32'(want.step_event), 32'(m_step_event));
                cmp_field("store_default", 32'(want.store_default), 32'(m_store_default));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress, %0d results outstanding", $time,
                     tick_exp.size());
            $display("FAIL rotary_knob_volume_channel_control");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        knob_qs     = QS_START;
        knob_last   = DIR_IDLE;
        knob_cnt[0] = 0;
        knob_cnt[1] = 0;
        knob_att    = '0;
        knob_ch     = '0;
        knob_mode   = 1'b0;
        knob_press  = '0;
        cfg_steps_att  = 4'd2;
        cfg_steps_ch   = 4'd4;
        cfg_max_att    = 8'd255;
        cfg_max_ch     = 4'd3;
        cfg_press_min  = 16'd50;
        cfg_long_press = 16'd1000;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Both directions, lower clamp, channel wrap below zero, all press kinds
        set_all(1, 1, 255, 15, 2, 6);
        turn(DIR_CW, 1, 1'b1);
        turn(DIR_CCW, 2, 1'b1);
        hold_switch(2);
        turn(DIR_CW, 1, 1'b1);
        turn(DIR_CCW, 2, 1'b1);
        hold_switch(6);
        hold_switch(1);
        hold_switch(2);
        wait_drain();

        // Lower the limits under the current values, no idling
        tx_idle_max = 0;
        rx_idle_max = 0;
        set_all(15, 15, 1, 0, 1, 32'(PRESS_SAT));
        turn(DIR_CCW, 1, 1'b1);
        hold_switch(1);
        turn(DIR_CW, 1, 1'b1);
        hold_switch(1);
        wait_drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_idle_max = (ph % 3 == 1 || ph == 2) ? 0 : 7;
            rx_idle_max = (ph % 3 == 2) ? 0 : 7;
            random_setting();
            random_ticks(RANDOM_TICKS);
            if (ph == 2) begin
                // stall the receiver while the sender keeps pushing requests
                @(posedge aclk);
                rx_long_cnt++;
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Drove %0d ticks over %0d register settings, with idling and a long stall.",
                 ticks_in, settings);
        $display("Checked %0d results: %0d store pulses, %0d mode changes, %0d mismatches.",
                 results_seen, store_seen, mode_changes, errors);
        if (errors == 0 && tick_exp.size() == 0) begin
            $display("PASS rotary_knob_volume_channel_control");
        end else begin
            $display("FAIL rotary_knob_volume_channel_control");
        end
        $finish;
    end

endmodule

>>> rotary_knob_volume_channel_control.f
src/rkv_pkg.sv
src/rkv_apb_regs.sv
src/rkv_knob_core.sv
src/rotary_knob_volume_channel_control.sv
dv/rotary_knob_volume_channel_control_test.sv
